// ===== hdl/sweep_cut_conductance_unit_defines.svh =====
// assertion macros shared by the sweep cut conductance unit
`ifndef SWEEP_CUT_CONDUCTANCE_UNIT_DEFINES_SVH
`define SWEEP_CUT_CONDUCTANCE_UNIT_DEFINES_SVH

// same-cycle implication
`define SCC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/scc_pkg.sv =====
// types and constants of the sweep cut conductance unit
package scc_pkg;

  localparam int NODE_W = 16;
  localparam int DEG_W  = 16;
  localparam int VOL_W  = 32;
  localparam int CUT_W  = 33;
  localparam int PROD_W = 64;

  // member bitmap, held as rows of a memory with one write and one read port
  localparam int MAX_NODES  = 65536;
  localparam int SLOT_W     = $clog2(MAX_NODES);
  localparam int MARK_ROW_W = 64;
  localparam int MARK_BIT_W = $clog2(MARK_ROW_W);
  localparam int MARK_ROWS  = MAX_NODES / MARK_ROW_W;
  localparam int MARK_RA_W  = $clog2(MARK_ROWS);

  // queue depths
  localparam int IQ_DEPTH = 2;
  localparam int IQ_AW    = $clog2(IQ_DEPTH);
  localparam int IQ_CW    = $clog2(IQ_DEPTH + 1);
  localparam int RQ_DEPTH = 2;
  localparam int RQ_AW    = $clog2(RQ_DEPTH);
  localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

  typedef enum logic [1:0] {
    ACT_BEGIN    = 2'd0,
    ACT_ADD      = 2'd1,
    ACT_NEIGHBOR = 2'd2,
    ACT_FINISH   = 2'd3
  } action_e;

  // classified item as it waits between front and back
  typedef struct packed {
    action_e                 action;
    logic [MARK_RA_W-1:0]    mark_row;
    logic [MARK_BIT_W-1:0]   mark_bit;
    logic [DEG_W-1:0]        degree;
    logic                    score_zero;
    logic [VOL_W-1:0]        total_volume;
  } item_t;

  typedef struct packed {
    logic [VOL_W-1:0] best_cut;
    logic [VOL_W-1:0] best_volume;
  } result_t;

endpackage

// ===== hdl/scc_front.sv =====
// front end: takes items, splits the node index into bitmap row and bit, queues them
module scc_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  output logic                     full_o,
  input  logic                     hold_i,
  input  logic [1:0]               action_i,
  input  logic [scc_pkg::NODE_W-1:0] node_id_i,
  input  logic [scc_pkg::DEG_W-1:0]  degree_i,
  input  logic                     score_zero_i,
  input  logic [scc_pkg::VOL_W-1:0]  total_volume_i,
  output logic                     head_valid_o,
  output scc_pkg::item_t           head_o,
  input  logic                     pop_i
);
  import scc_pkg::*;

  item_t            slot_q [IQ_DEPTH];
  logic [IQ_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [IQ_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [IQ_CW-1:0] count_q, count_d;
  item_t            item;
  logic             wr_en;
  logic             rd_en;

  always_comb begin
    item.action       = action_e'(action_i);
    item.mark_row     = node_id_i[SLOT_W-1:MARK_BIT_W];
    item.mark_bit     = node_id_i[MARK_BIT_W-1:0];
    item.degree       = degree_i;
    item.score_zero   = score_zero_i;
    item.total_volume = total_volume_i;
  end

  assign full_o       = (count_q == IQ_CW'(IQ_DEPTH)) || hold_i;
  assign head_valid_o = (count_q != '0);
  assign head_o       = slot_q[rd_ptr_q];
  assign wr_en        = push_i && !full_o;
  assign rd_en        = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == IQ_AW'(IQ_DEPTH - 1)) ? '0 : wr_ptr_q + IQ_AW'(1);
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == IQ_AW'(IQ_DEPTH - 1)) ? '0 : rd_ptr_q + IQ_AW'(1);
    end
    if (wr_en && !rd_en) begin
      count_d = count_q + IQ_CW'(1);
    end else if (rd_en && !wr_en) begin
      count_d = count_q - IQ_CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_q[wr_ptr_q] <= item;
    end
  end

endmodule

// ===== hdl/scc_back.sv =====
// back end: member bitmap, cut and volume counters, exact fraction compare
`include "sweep_cut_conductance_unit_defines.svh"

module scc_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             head_valid_i,
  input  scc_pkg::item_t   head_i,
  output logic             head_pop_o,
  output logic             init_busy_o,
  output logic             res_push_o,
  output scc_pkg::result_t res_o,
  input  logic             res_full_i
);
  import scc_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ADD_WR,
    S_NBR,
    S_EVAL0,
    S_EVAL1,
    S_EVAL2,
    S_EVAL3
  } state_e;

  state_e                state_q;
  logic                  init_q;
  logic [MARK_RA_W-1:0]  clr_addr_q;
  logic [CUT_W-1:0]      cut_q;
  logic [VOL_W-1:0]      set_vol_q;
  logic [VOL_W-1:0]      best_num_q;
  logic [VOL_W-1:0]      best_den_q;
  logic [DEG_W-1:0]      rem_q;
  logic                  stopped_q;
  item_t                 cur_q;
  logic [VOL_W-1:0]      comp_q;
  logic [VOL_W-1:0]      minv_q;
  logic [PROD_W-1:0]     lhs_q;
  logic [PROD_W-1:0]     rhs_q;

  logic [MARK_ROW_W-1:0] mark_mem [MARK_ROWS];
  logic [MARK_ROW_W-1:0] rd_q;
  logic                  mem_we;
  logic [MARK_RA_W-1:0]  mem_waddr;
  logic [MARK_ROW_W-1:0] mem_wdata;
  logic                  mem_re;
  logic                  is_member;

  assign init_busy_o = init_q;
  assign res_o       = '{best_cut: best_num_q, best_volume: best_den_q};
  assign is_member   = rd_q[cur_q.mark_bit];

  always_comb begin
    head_pop_o = 1'b0;
    res_push_o = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = clr_addr_q;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_IDLE: begin
        if (head_valid_i) begin
          mem_re = 1'b1;
          if (head_i.action == ACT_FINISH) begin
            res_push_o = !res_full_i;
            head_pop_o = !res_full_i;
          end else begin
            head_pop_o = 1'b1;
          end
        end
      end
      S_ADD_WR: begin
        mem_we    = 1'b1;
        mem_waddr = cur_q.mark_row;
        mem_wdata = rd_q | (MARK_ROW_W'(1) << cur_q.mark_bit);
      end
      S_NBR, S_EVAL0, S_EVAL1, S_EVAL2, S_EVAL3: begin
      end
    endcase
  end

  // bitmap memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mark_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mark_mem[head_i.mark_row];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      init_q     <= 1'b1;
      clr_addr_q <= '0;
      cut_q      <= '0;
      set_vol_q  <= '0;
      best_num_q <= VOL_W'(1);
      best_den_q <= VOL_W'(1);
      rem_q      <= '0;
      stopped_q  <= 1'b0;
      cur_q      <= '0;
      comp_q     <= '0;
      minv_q     <= '0;
      lhs_q      <= '0;
      rhs_q      <= '0;
    end else begin
      unique case (state_q)
        S_CLEAR: begin
          if (clr_addr_q == MARK_RA_W'(MARK_ROWS - 1)) begin
            clr_addr_q <= '0;
            init_q     <= 1'b0;
            state_q    <= S_IDLE;
          end else begin
            clr_addr_q <= clr_addr_q + MARK_RA_W'(1);
          end
        end
        S_IDLE: begin
          if (head_pop_o) begin
            cur_q <= head_i;
            unique case (head_i.action)
              ACT_BEGIN: begin
                cut_q      <= '0;
                set_vol_q  <= '0;
                best_num_q <= VOL_W'(1);
                best_den_q <= VOL_W'(1);
                rem_q      <= '0;
                stopped_q  <= 1'b0;
                clr_addr_q <= '0;
                state_q    <= S_CLEAR;
              end
              ACT_ADD: begin
                if (!stopped_q && rem_q == '0) begin
                  if (head_i.score_zero) begin
                    stopped_q <= 1'b1;
                  end else if (head_i.degree != '0) begin
                    set_vol_q <= set_vol_q + VOL_W'(head_i.degree);
                    rem_q     <= head_i.degree;
                    state_q   <= S_ADD_WR;
                  end
                end
              end
              ACT_NEIGHBOR: begin
                if (!stopped_q && rem_q != '0) begin
                  state_q <= S_NBR;
                end
              end
              ACT_FINISH: begin
              end
            endcase
          end
        end
        S_ADD_WR: begin
          state_q <= S_IDLE;
        end
        S_NBR: begin
          cut_q   <= is_member ? cut_q - CUT_W'(1) : cut_q + CUT_W'(1);
          rem_q   <= rem_q - DEG_W'(1);
          state_q <= (rem_q == DEG_W'(1)) ? S_EVAL0 : S_IDLE;
        end
        S_EVAL0: begin
          // a cut of zero or below is dropped and not compared
          if (cut_q == '0 || cut_q[CUT_W-1]) begin
            cut_q   <= '0;
            state_q <= S_IDLE;
          end else begin
            comp_q  <= (set_vol_q > cur_q.total_volume) ? '0
                       : cur_q.total_volume - set_vol_q;
            state_q <= S_EVAL1;
          end
        end
        S_EVAL1: begin
          minv_q  <= (set_vol_q > comp_q) ? comp_q : set_vol_q;
          state_q <= S_EVAL2;
        end
        S_EVAL2: begin
          if (minv_q == '0) begin
            state_q <= S_IDLE;
          end else begin
            lhs_q   <= PROD_W'(cut_q[VOL_W-1:0]) * PROD_W'(best_den_q);
            rhs_q   <= PROD_W'(best_num_q) * PROD_W'(minv_q);
            state_q <= S_EVAL3;
          end
        end
        S_EVAL3: begin
          // ties go to the newer prefix
          if (lhs_q <= rhs_q) begin
            best_num_q <= cut_q[VOL_W-1:0];
            best_den_q <= minv_q;
          end
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  `SCC_ASSERT_IMPLY(a_stop_no_pending, clk_i, rst_ni, stopped_q, rem_q == '0, "stopped with neighbors pending")
  `SCC_ASSERT_IMPLY(a_best_den_nonzero, clk_i, rst_ni, !init_q, best_den_q != '0, "zero best denominator")
  `SCC_ASSERT_IMPLY(a_push_room, clk_i, rst_ni, res_push_o, !res_full_i, "result pushed into full queue")
  `SCC_ASSERT_IMPLY(a_nbr_pending, clk_i, rst_ni, state_q == S_NBR, rem_q != '0, "neighbor step with none pending")
  `SCC_ASSERT_NEXT(a_add_wr_done, clk_i, rst_ni, state_q == S_ADD_WR, state_q == S_IDLE, "add write not single cycle")

endmodule

// ===== hdl/scc_res_queue.sv =====
// result queue between the back end and the result port
module scc_res_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  scc_pkg::result_t data_i,
  output logic             full_o,
  output logic             empty_o,
  input  logic             pop_i,
  output scc_pkg::result_t data_o
);
  import scc_pkg::*;

  result_t          slot_q [RQ_DEPTH];
  logic [RQ_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [RQ_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [RQ_CW-1:0] count_q, count_d;
  logic             wr_en;
  logic             rd_en;

  assign full_o  = (count_q == RQ_CW'(RQ_DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = slot_q[rd_ptr_q];
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == RQ_AW'(RQ_DEPTH - 1)) ? '0 : wr_ptr_q + RQ_AW'(1);
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == RQ_AW'(RQ_DEPTH - 1)) ? '0 : rd_ptr_q + RQ_AW'(1);
    end
    if (wr_en && !rd_en) begin
      count_d = count_q + RQ_CW'(1);
    end else if (rd_en && !wr_en) begin
      count_d = count_q - RQ_CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== hdl/sweep_cut_conductance_unit.sv =====
// top level of the sweep cut conductance unit
//
//   channel   direction  handshake           payload
//   items     in         push / full         action_i node_id_i degree_i score_zero_i
//   results   out        empty / pop         best_cut_o best_volume_o
//   config    in         cfg_we_i            cfg_wdata_i (total volume)
//
// neighbor item: mark read, then counter update; for the last neighbor of a node
//   EVAL0 ends a cut of zero or below, EVAL2 a zero min volume, else EVAL3 compares
// add item: read-modify-write of one 64-bit bitmap row; finish and ignored
//   items are taken in S_IDLE alone, a finish waits while the result queue is full
// begin item: the bitmap is cleared one row per cycle through its write port
// after reset the same clearing pass runs while full stays high
// a 2-entry item queue and a 2-entry result queue let each side stall on its own
module sweep_cut_conductance_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic [1:0]                   action_i,
  input  logic [scc_pkg::NODE_W-1:0]   node_id_i,
  input  logic [scc_pkg::DEG_W-1:0]    degree_i,
  input  logic                         score_zero_i,
  output logic                         empty,
  input  logic                         pop,
  output logic [scc_pkg::VOL_W-1:0]    best_cut_o,
  output logic [scc_pkg::VOL_W-1:0]    best_volume_o,
  input  logic                         cfg_we_i,
  input  logic [scc_pkg::VOL_W-1:0]    cfg_wdata_i
);
  import scc_pkg::*;

  logic [VOL_W-1:0] total_volume_q;
  logic             head_valid;
  item_t            head;
  logic             head_pop;
  logic             init_busy;
  logic             res_push;
  result_t          res_in;
  logic             res_full;
  result_t          res_out;

  // total volume register; each item carries a copy taken at its transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_volume_q <= '0;
    end else if (cfg_we_i) begin
      total_volume_q <= cfg_wdata_i;
    end
  end

  // front: item transfer and classification, no transfer during the reset clear
  scc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_o         (full),
    .hold_i         (init_busy),
    .action_i       (action_i),
    .node_id_i      (node_id_i),
    .degree_i       (degree_i),
    .score_zero_i   (score_zero_i),
    .total_volume_i (total_volume_q),
    .head_valid_o   (head_valid),
    .head_o         (head),
    .pop_i          (head_pop)
  );

  // back: bitmap, counters and best fraction
  scc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .head_pop_o   (head_pop),
    .init_busy_o  (init_busy),
    .res_push_o   (res_push),
    .res_o        (res_in),
    .res_full_i   (res_full)
  );

  // finished results wait here until popped
  scc_res_queue u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .empty_o (empty),
    .pop_i   (pop),
    .data_o  (res_out)
  );

  assign best_cut_o    = res_out.best_cut;
  assign best_volume_o = res_out.best_volume;

endmodule
